>>> rtl/ckbc_pkg.sv
package ckbc_pkg;

    // Largest frame side in pixels
    localparam int MAX_DIM = 4096;
    // Position width and dimension width (dimension can hold MAX_DIM itself)
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = CW + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_RED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_GREEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BLUE     = 3'd4;

    // Stream widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 80;

    // Result kinds
    localparam logic KIND_GEOMETRY = 1'b0;
    localparam logic KIND_PIXEL    = 1'b1;

    // Bounding box of the keyed region
    typedef struct packed {
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [CW-1:0] right;
        logic [CW-1:0] bottom;
        logic          any;
    } box_t;

    // Crop window
    typedef struct packed {
        logic [CW-1:0] left;
        logic [CW-1:0] top;
        logic [DW-1:0] width;
        logic [DW-1:0] height;
    } window_t;

endpackage

>>> rtl/ckbc_window.sv
// Turns a finished bounding box into the aligned crop window.
module ckbc_window (
    input  ckbc_pkg::box_t              box,
    input  logic [ckbc_pkg::DW-1:0]     frame_w,
    output ckbc_pkg::window_t           win
);

    localparam int CW = ckbc_pkg::CW;
    localparam int DW = ckbc_pkg::DW;

    logic [DW-1:0] min_x;
    logic [DW-1:0] max_x;
    logic [DW-1:0] orig;
    logic [DW-1:0] room;
    logic [DW-1:0] slack;
    logic [DW-1:0] nw_down;
    logic [DW-1:0] nw_up;
    logic [DW-1:0] height;
    logic [2:0]    diff;
    logic [2:0]    sr;
    logic [2:0]    sl;
    logic [DW-1:0] shift;

    // Box extents and the spare room around it
    assign min_x   = {1'b0, box.left};
    assign max_x   = {1'b0, box.right} + DW'(1);
    assign orig    = max_x - min_x;
    assign room    = frame_w - max_x;
    assign slack   = frame_w - orig;
    assign nw_down = {orig[DW-1:2], 2'b00};
    assign nw_up   = nw_down + DW'(4);
    assign height  = {1'b0, box.bottom} + DW'(1) - {1'b0, box.top};

    // Growth split: left half rounds down, right takes the rest
    assign diff = 3'd4 - {1'b0, orig[1:0]};
    assign sr   = diff >> 1;
    assign sl   = diff - sr;

    // Left shift when growing, clamped to the frame edges
    always_comb begin
        if (min_x < DW'(sr)) begin
            shift = min_x;
        end else if (room < DW'(sl)) begin
            shift = DW'(diff) - room;
        end else begin
            shift = DW'(sr);
        end
    end

    always_comb begin
        win.top    = box.top;
        win.height = {height[DW-1:2], 2'b00};
        if (orig[1:0] == 2'b00) begin
            win.left  = box.left;
            win.width = orig;
        end else if (slack < DW'(4)) begin
            // Frame too narrow to grow: shrink and center
            win.left  = box.left + CW'(orig[1]);
            win.width = nw_down;
        end else begin
            win.left  = box.left - shift[CW-1:0];
            win.width = nw_up;
        end
        if (!box.any) begin
            win = '0;
        end
    end

endmodule

>>> rtl/color_key_bbox_crop.sv
// Color-keyed bounding-box crop. Each frame is streamed twice in raster order,
// one item per pixel carrying an image pixel and a mask pixel; s_tuser selects
// the pass (0 measure, 1 crop). A pixel is in the region when its mask color
// equals the key color. The measure pass tracks the region's bounding box and,
// on the frame's last pixel, emits one geometry item: a window whose width is
// aligned to four (shrunk and centered, or grown and clamped to the frame), whose
// height is rounded down to four, and which is all zero with the empty flag set
// when nothing matched. The crop pass emits the window's pixels with pixels
// outside the region zeroed, tlast on the window's final pixel. The block takes
// one item per clock: an input register holds the position, match and box of an
// item, and the window math and crop test sit between it and the output register;
// the input stalls only when both registers hold items and the output item is
// not taken. Configuration (frame size, key color) is to be written by the user
// while the stream is idle, which the block does not enforce; a frame size write
// restarts the raster position and clears the box.
module color_key_bbox_crop (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // image_red, image_green, image_blue, mask_red, mask_green, mask_blue
    input  logic [ckbc_pkg::S_DATA_W-1:0]     s_tdata,
    // func
    input  logic [0:0]                        s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // win_x, win_y, win_w, win_h, empty_res, out_red, out_green, out_blue, zero fill
    output logic [ckbc_pkg::M_DATA_W-1:0]     m_tdata,
    // kind
    output logic [0:0]                        m_tuser,
    output logic                              m_tlast,
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ckbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ckbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CW = ckbc_pkg::CW;
    localparam int DW = ckbc_pkg::DW;
    localparam int MW = ckbc_pkg::M_DATA_W;

    // Configuration
    logic [DW-1:0] fw_reg, fw_next;
    logic [DW-1:0] fh_reg, fh_next;
    logic [7:0]    key_r_reg, key_r_next;
    logic [7:0]    key_g_reg, key_g_next;
    logic [7:0]    key_b_reg, key_b_next;
    logic          dim_write;
    logic [DW-1:0] cfg_dim;

    // Raster position and running box
    logic [CW-1:0]     col_reg, col_next;
    logic [CW-1:0]     row_reg, row_next;
    ckbc_pkg::box_t    box_reg, box_next, box_upd, box_clear;

    // Input stage
    logic              p_valid_reg, p_valid_next;
    logic              p_func_reg;
    logic              p_match_reg;
    logic              p_end_reg;
    logic [CW-1:0]     p_col_reg;
    logic [CW-1:0]     p_row_reg;
    logic [23:0]       p_image_reg;
    ckbc_pkg::box_t    p_box_reg;

    // Window and output stage
    ckbc_pkg::window_t win_reg, win_next, win_calc;
    logic              m_valid_reg, m_valid_next;
    logic [MW-1:0]     m_data_reg, m_data_next;
    logic              m_kind_reg, m_kind_next;
    logic              m_last_reg, m_last_next;

    logic          s_accept;
    logic          adv;
    logic          func;
    logic          match;
    logic          end_row;
    logic          end_frame;
    logic          geom;
    logic          hit;
    logic          is_last;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic [23:0]   pix;

    assign cfg_ready = 1'b1;
    assign s_tready  = !p_valid_reg || adv;
    assign s_accept  = s_tvalid && s_tready;
    assign adv       = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_kind_reg;
    assign m_tlast    = m_last_reg;

    // Frame size clamped to 1..MAX_DIM on write
    always_comb begin
        if (cfg_data == '0) begin
            cfg_dim = DW'(1);
        end else if (cfg_data > DW'(ckbc_pkg::MAX_DIM)) begin
            cfg_dim = DW'(ckbc_pkg::MAX_DIM);
        end else begin
            cfg_dim = cfg_data;
        end
    end

    // Register write decode
    always_comb begin
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        key_r_next = key_r_reg;
        key_g_next = key_g_reg;
        key_b_next = key_b_reg;
        dim_write  = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                ckbc_pkg::CFG_FRAME_WIDTH: begin
                    fw_next   = cfg_dim;
                    dim_write = 1'b1;
                end
                ckbc_pkg::CFG_FRAME_HEIGHT: begin
                    fh_next   = cfg_dim;
                    dim_write = 1'b1;
                end
                ckbc_pkg::CFG_KEY_RED:   key_r_next = cfg_data[7:0];
                ckbc_pkg::CFG_KEY_GREEN: key_g_next = cfg_data[7:0];
                ckbc_pkg::CFG_KEY_BLUE:  key_b_next = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Key match and raster wrap for the incoming item
    assign func      = s_tuser[0];
    assign match     = s_tdata[31:24] == key_r_reg && s_tdata[39:32] == key_g_reg &&
                       s_tdata[47:40] == key_b_reg;
    assign end_row   = ({1'b0, col_reg} + DW'(1)) >= fw_reg;
    assign end_frame = end_row && (({1'b0, row_reg} + DW'(1)) >= fh_reg);

    // Box extended by the incoming item
    always_comb begin
        box_clear        = '0;
        box_clear.left   = '1;
        box_clear.top    = '1;
        box_upd          = box_reg;
        if (!func && match) begin
            if (col_reg < box_reg.left)   box_upd.left   = col_reg;
            if (col_reg > box_reg.right)  box_upd.right  = col_reg;
            if (row_reg < box_reg.top)    box_upd.top    = row_reg;
            if (row_reg > box_reg.bottom) box_upd.bottom = row_reg;
            box_upd.any = 1'b1;
        end
    end

    // Position and box update
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        box_next = box_reg;
        if (dim_write) begin
            col_next = '0;
            row_next = '0;
            box_next = box_clear;
        end else if (s_accept) begin
            if (end_frame) begin
                col_next = '0;
                row_next = '0;
            end else if (end_row) begin
                col_next = '0;
                row_next = row_reg + CW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
            box_next = (!func && end_frame) ? box_clear : box_upd;
        end
    end

    // Window from the finished box
    ckbc_window u_window (
        .box     (p_box_reg),
        .frame_w (fw_reg),
        .win     (win_calc)
    );

    // Crop test against the current window
    assign dx      = {1'b0, p_col_reg} - {1'b0, win_reg.left};
    assign dy      = {1'b0, p_row_reg} - {1'b0, win_reg.top};
    assign hit     = p_func_reg && win_reg.width != '0 && win_reg.height != '0 &&
                     p_col_reg >= win_reg.left && dx < win_reg.width &&
                     p_row_reg >= win_reg.top && dy < win_reg.height;
    assign is_last = (dx + DW'(1)) == win_reg.width && (dy + DW'(1)) == win_reg.height;
    assign geom    = !p_func_reg && p_end_reg;
    assign pix     = p_match_reg ? p_image_reg : '0;

    // Stage advance and result formation
    always_comb begin
        p_valid_next = p_valid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_kind_next  = m_kind_reg;
        m_last_next  = m_last_reg;
        win_next     = win_reg;
        if (adv) begin
            p_valid_next = 1'b0;
            m_valid_next = p_valid_reg && (geom || hit);
            if (geom) begin
                win_next    = win_calc;
                m_kind_next = ckbc_pkg::KIND_GEOMETRY;
                m_last_next = 1'b0;
                m_data_next = MW'({!p_box_reg.any, win_calc.height, win_calc.width,
                                   win_calc.top, win_calc.left});
            end else begin
                m_kind_next = ckbc_pkg::KIND_PIXEL;
                m_last_next = is_last;
                m_data_next = MW'({pix, 51'd0});
            end
            if (!p_valid_reg) begin
                win_next = win_reg;
            end
        end
        if (s_accept) begin
            p_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= DW'(640);
            fh_reg      <= DW'(480);
            key_r_reg   <= '0;
            key_g_reg   <= '0;
            key_b_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            box_reg     <= '{left: '1, top: '1, right: '0, bottom: '0, any: 1'b0};
            win_reg     <= '0;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            key_r_reg   <= key_r_next;
            key_g_reg   <= key_g_next;
            key_b_reg   <= key_b_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            box_reg     <= box_next;
            win_reg     <= win_next;
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p_func_reg  <= func;
            p_match_reg <= match;
            p_end_reg   <= end_frame;
            p_col_reg   <= col_reg;
            p_row_reg   <= row_reg;
            p_image_reg <= s_tdata[23:0];
            p_box_reg   <= box_upd;
        end
        m_data_reg <= m_data_next;
        m_kind_reg <= m_kind_next;
        m_last_reg <= m_last_next;
    end

endmodule

>>> verif/tb_color_key_bbox_crop.sv
module tb_color_key_bbox_crop;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = ckbc_pkg::CW;
    localparam int DW         = ckbc_pkg::DW;
    localparam int CFG_IDX_W  = ckbc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = ckbc_pkg::CFG_DATA_W;

    localparam int RANDOM_PIXELS = 1250;
    localparam int SETTLE_CYCLES = 8;   // output pipe is two deep, leave margin
    localparam int MAX_REPORTS   = 10;
    localparam int ALIGN         = 4;   // window width/height granularity
    localparam int HOLD_CYCLES   = 300;
    localparam int WIDE_COLS     = 63;
    localparam int TALL_ROWS     = 40;

    typedef struct packed {
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
    } rgb_t;

    // One result item, unpacked into its fields
    typedef struct {
        logic          kind;
        logic [CW-1:0] win_x;
        logic [CW-1:0] win_y;
        logic [DW-1:0] win_w;
        logic [DW-1:0] win_h;
        logic          empty;
        rgb_t          pix;
        logic          last;
    } crop_out_t;

    typedef enum int {FRAME_CLEAN, FRAME_MIXED_PASS, FRAME_REMASK} frame_mode_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ckbc_pkg::S_DATA_W-1:0]   s_tdata;
    logic [0:0]                      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ckbc_pkg::M_DATA_W-1:0]   m_tdata;
    logic [0:0]                      m_tuser;
    logic                            m_tlast;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [CFG_IDX_W-1:0]            cfg_index;
    logic [CFG_DATA_W-1:0]           cfg_data;

    color_key_bbox_crop dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: registers, raster position, box, stored window
    int   frm_w_reg, frm_h_reg;
    rgb_t key_rgb;
    int   col_pos, row_pos;
    int   bb_left, bb_top, bb_right, bb_bottom;
    bit   bb_any;
    int   win_left, win_top, win_width, win_height;

    crop_out_t crop_out_q[$];

    int err_count;
    int pixels_sent;
    bit tx_gaps_on;
    bit rx_gaps_on;
    int rx_hold_request;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_color_key_bbox_crop: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // Crop predictor
    // ---------------------------------------------------------------
    function automatic int clamp_dim(int v);
        if (v == 0) return 1;
        if (v > ckbc_pkg::MAX_DIM) return ckbc_pkg::MAX_DIM;
        return v;
    endfunction

    function automatic void clear_bbox();
        bb_left   = ckbc_pkg::MAX_DIM - 1;
        bb_top    = ckbc_pkg::MAX_DIM - 1;
        bb_right  = 0;
        bb_bottom = 0;
        bb_any    = 1'b0;
    endfunction

    function automatic void model_reset();
        frm_w_reg  = 640;
        frm_h_reg  = 480;
        key_rgb    = '0;
        col_pos    = 0;
        row_pos    = 0;
        clear_bbox();
        win_left   = 0;
        win_top    = 0;
        win_width  = 0;
        win_height = 0;
    endfunction

    function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            ckbc_pkg::CFG_FRAME_WIDTH: begin
                frm_w_reg = int'(data);
                col_pos = 0;
                row_pos = 0;
                clear_bbox();
            end
            ckbc_pkg::CFG_FRAME_HEIGHT: begin
                frm_h_reg = int'(data);
                col_pos = 0;
                row_pos = 0;
                clear_bbox();
            end
            ckbc_pkg::CFG_KEY_RED:   key_rgb.r = data[7:0];
            ckbc_pkg::CFG_KEY_GREEN: key_rgb.g = data[7:0];
            ckbc_pkg::CFG_KEY_BLUE:  key_rgb.b = data[7:0];
            default: ;
        endcase
    endfunction

    // Width to a multiple of four: shrink and center when the frame has no room,
    // otherwise grow and keep inside the frame. Height rounds down.
    function automatic void fit_window(int fw);
        int min_x, max_x, min_y, max_y;
        int orig, nw, diff, sr, sl, room, shift;
        min_x = bb_left;
        max_x = bb_right + 1;
        min_y = bb_top;
        max_y = bb_bottom + 1;
        orig  = max_x - min_x;
        nw    = orig;
        if (nw % ALIGN != 0) begin
            if (fw - nw < ALIGN) begin
                nw = nw / ALIGN * ALIGN;
                min_x += (orig - nw) / 2;
            end else begin
                nw   = (nw / ALIGN + 1) * ALIGN;
                diff = nw - orig;
                sr   = diff / 2;
                sl   = diff - sr;
                room = fw - max_x;
                if (min_x < sr) shift = min_x;
                else if (room < sl) shift = diff - room;
                else shift = sr;
                min_x -= shift;
            end
        end
        win_left   = min_x;
        win_top    = min_y;
        win_width  = nw;
        win_height = (max_y - min_y) / ALIGN * ALIGN;
    endfunction

    function automatic void predict_pixel(bit func, rgb_t img, rgb_t msk);
        int        w, h, c, r;
        bit        hit, end_row, end_frame;
        crop_out_t o;
        w = clamp_dim(frm_w_reg);
        h = clamp_dim(frm_h_reg);
        c = col_pos;
        r = row_pos;
        hit = (msk == key_rgb);
        end_row = (c + 1 >= w);
        end_frame = end_row && (r + 1 >= h);
        o = '{default: '0};

        // raster position is shared by both passes
        if (end_frame) begin
            col_pos = 0;
            row_pos = 0;
        end else if (end_row) begin
            col_pos = 0;
            row_pos = r + 1;
        end else begin
            col_pos = c + 1;
        end

        if (!func) begin
            if (hit) begin
                if (c < bb_left) bb_left = c;
                if (c > bb_right) bb_right = c;
                if (r < bb_top) bb_top = r;
                if (r > bb_bottom) bb_bottom = r;
                bb_any = 1'b1;
            end
            if (end_frame) begin
                if (bb_any) begin
                    fit_window(w);
                end else begin
                    win_left   = 0;
                    win_top    = 0;
                    win_width  = 0;
                    win_height = 0;
                end
                o.kind  = ckbc_pkg::KIND_GEOMETRY;
                o.win_x = CW'(win_left);
                o.win_y = CW'(win_top);
                o.win_w = DW'(win_width);
                o.win_h = DW'(win_height);
                o.empty = !bb_any;
                clear_bbox();
                crop_out_q.push_back(o);
            end
        end else if (win_width != 0 && win_height != 0 &&
                     c >= win_left && c < win_left + win_width &&
                     r >= win_top && r < win_top + win_height) begin
            o.kind = ckbc_pkg::KIND_PIXEL;
            if (hit) o.pix = img;
            o.last = (c == win_left + win_width - 1) && (r == win_top + win_height - 1);
            crop_out_q.push_back(o);
        end
    endfunction

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    function automatic string fmt_out(crop_out_t o);
        return $sformatf("kind=%0d x=%0d y=%0d w=%0d h=%0d empty=%0d rgb=%h/%h/%h last=%0d",
                         o.kind, o.win_x, o.win_y, o.win_w, o.win_h, o.empty,
                         o.pix.r, o.pix.g, o.pix.b, o.last);
    endfunction

    function automatic void flag_error(string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    always @(posedge aclk) begin
        crop_out_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind  = m_tuser[0];
            got.win_x = m_tdata[11:0];
            got.win_y = m_tdata[23:12];
            got.win_w = m_tdata[36:24];
            got.win_h = m_tdata[49:37];
            got.empty = m_tdata[50];
            got.pix   = m_tdata[74:51];
            got.last  = m_tlast;
            if (crop_out_q.size() == 0) begin
                flag_error({"unexpected result: ", fmt_out(got)});
            end else begin
                want = crop_out_q.pop_front();
                if (got.kind !== want.kind || got.win_x !== want.win_x ||
                    got.win_y !== want.win_y || got.win_w !== want.win_w ||
                    got.win_h !== want.win_h || got.empty !== want.empty ||
                    got.pix.r !== want.pix.r || got.pix.g !== want.pix.g ||
                    got.pix.b !== want.pix.b || got.last !== want.last) begin
                    flag_error({"mismatch: expected ", fmt_out(want),
                                " actual ", fmt_out(got)});
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stream drivers
    // ---------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random ready gaps, plus a long hold when a test asks for one
    initial begin
        int gap_left;
        gap_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_request > 0) begin
                m_tready = 1'b0;
                repeat (rx_hold_request) @(negedge aclk);
                rx_hold_request = 0;
            end
            if (gap_left > 0) begin
                m_tready = 1'b0;
                gap_left--;
            end else begin
                m_tready = 1'b1;
                if (rx_gaps_on) gap_left = pick_gap();
            end
        end
    end

    task automatic send_pixel(bit func, rgb_t img, rgb_t msk);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = func;
        s_tdata  = {msk, img};
        do @(posedge aclk); while (!s_tready);
        predict_pixel(func, img, msk);
        pixels_sent++;
    endtask

    // Stop offering items and let every expected result come out
    task automatic drain_stream();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (crop_out_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        model_reg_write(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic rgb_t pick_image();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return rgb_t'(24'hFFFFFF);
        if (roll == 1) return rgb_t'(24'h000000);
        return rgb_t'(24'($urandom));
    endfunction

    // Mask off the key: random, one bit off, or one channel replaced
    function automatic rgb_t other_mask();
        rgb_t m;
        m = key_rgb;
        case ($urandom_range(0, 2))
            0: m = rgb_t'(24'($urandom));
            1: m = m ^ rgb_t'(24'h1 << $urandom_range(0, 23));
            default: begin
                case ($urandom_range(0, 2))
                    0: m.r = 8'($urandom);
                    1: m.g = 8'($urandom);
                    default: m.b = 8'($urandom);
                endcase
            end
        endcase
        return m;
    endfunction

    // One frame: a measure pass, then optionally the crop pass over the same masks (remask mode redraws some)
    task automatic stream_frame(frame_mode_t mode, bit keyed, int x0, int x1,
                                int y0, int y1, int density, bit with_crop);
        int   w, h;
        rgb_t masks[];
        bit   fn;
        w = clamp_dim(frm_w_reg);
        h = clamp_dim(frm_h_reg);
        masks = new[w * h];
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                if (keyed && x >= x0 && x <= x1 && y >= y0 && y <= y1 &&
                    $urandom_range(1, 100) <= density)
                    masks[y * w + x] = key_rgb;
                else
                    masks[y * w + x] = other_mask();
            end
        end
        for (int i = 0; i < w * h; i++) begin
            fn = (mode == FRAME_MIXED_PASS) ? 1'($urandom) : 1'b0;
            send_pixel(fn, pick_image(), masks[i]);
        end
        if (with_crop) begin
            for (int i = 0; i < w * h; i++) begin
                fn = (mode == FRAME_MIXED_PASS) ? 1'($urandom) : 1'b1;
                if (mode == FRAME_REMASK && $urandom_range(0, 1) == 1)
                    masks[i] = ($urandom_range(0, 1) == 1) ? key_rgb : other_mask();
                send_pixel(fn, pick_image(), masks[i]);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Small hand-built frames; keys are still at their reset value here
    task automatic test_directed();
        rgb_t msk;
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'd4);
        write_reg(ckbc_pkg::CFG_FRAME_HEIGHT, 13'd4);
        // two opposite corners keyed, the rest one bit away from the key
        for (int i = 0; i < 16; i++) begin
            msk = (i == 0 || i == 15) ? key_rgb : key_rgb ^ rgb_t'(24'h1 << (i + 8));
            send_pixel(1'b0, (i % 2 == 0) ? rgb_t'(24'hFFFFFF) : rgb_t'(24'h000000), msk);
        end
        // first row of the crop pass only; the size write below restarts the raster
        send_pixel(1'b1, rgb_t'(24'hA5C3FF), key_rgb);
        send_pixel(1'b1, rgb_t'(24'hFFFFFF), key_rgb ^ rgb_t'(24'h000001));
        send_pixel(1'b1, rgb_t'(24'h000000), key_rgb);
        send_pixel(1'b1, rgb_t'(24'h123456), key_rgb);
        drain_stream();
        // zero sizes act as one: every item ends a frame
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'd0);
        write_reg(ckbc_pkg::CFG_FRAME_HEIGHT, 13'd0);
        send_pixel(1'b0, rgb_t'(24'hFFFFFF), key_rgb);
        send_pixel(1'b1, rgb_t'(24'hFFFFFF), key_rgb);
        send_pixel(1'b0, rgb_t'(24'h000000), key_rgb ^ rgb_t'(24'hFFFFFF));
        drain_stream();
    endtask

    // Output held off long enough that the block must stall its input
    task automatic test_backpressure();
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'd8);
        write_reg(ckbc_pkg::CFG_FRAME_HEIGHT, 13'd8);
        tx_gaps_on = 1'b0;
        rx_hold_request = HOLD_CYCLES;
        stream_frame(FRAME_CLEAN, 1'b1, 0, 7, 0, 7, 100, 1'b1);
        drain_stream();
        tx_gaps_on = 1'b1;
    endtask

    // A frame size write mid-frame drops the position and the box
    task automatic test_restart_on_resize();
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'd6);
        write_reg(ckbc_pkg::CFG_FRAME_HEIGHT, 13'd5);
        for (int i = 0; i < 13; i++) send_pixel(1'b0, pick_image(), key_rgb);
        drain_stream();
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'd6);
        stream_frame(FRAME_CLEAN, 1'b1, 3, 5, 2, 4, 80, 1'b1);
        drain_stream();
    endtask

    // Wide row: full-width region with no room to grow, then a region against
    // the right edge
    task automatic test_wide_frame();
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'(WIDE_COLS));
        write_reg(ckbc_pkg::CFG_FRAME_HEIGHT, 13'd1);
        stream_frame(FRAME_CLEAN, 1'b1, 0, WIDE_COLS - 1, 0, 0, 100, 1'b0);
        drain_stream();
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'(WIDE_COLS));
        stream_frame(FRAME_CLEAN, 1'b1, WIDE_COLS - 3, WIDE_COLS - 1, 0, 0, 100, 1'b1);
        drain_stream();
    endtask

    // Tall frame, one pixel wide, region in the bottom rows
    task automatic test_tall_frame();
        write_reg(ckbc_pkg::CFG_FRAME_WIDTH, 13'd0);
        write_reg(ckbc_pkg::CFG_FRAME_HEIGHT, 13'(TALL_ROWS));
        stream_frame(FRAME_CLEAN, 1'b1, 0, 0, TALL_ROWS - 6, TALL_ROWS - 1, 100, 1'b0);
        drain_stream();
    endtask

    function automatic logic [7:0] pick_key_channel();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Random small frames, sizes, keys and idling patterns
    task automatic test_random_frames();
        int          start, w, h, x0, x1, y0, y1, roll;
        bit          first;
        frame_mode_t mode;
        start = pixels_sent;
        first = 1'b1;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            if (first || $urandom_range(0, 2) == 0) begin
                drain_stream();
                write_reg(ckbc_pkg::CFG_FRAME_WIDTH,
                          ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 12)));
                write_reg(ckbc_pkg::CFG_FRAME_HEIGHT,
                          ($urandom_range(0, 19) == 0) ? 13'd0 : 13'($urandom_range(1, 10)));
                write_reg(ckbc_pkg::CFG_KEY_RED,   {5'($urandom), pick_key_channel()});
                write_reg(ckbc_pkg::CFG_KEY_GREEN, {5'($urandom), pick_key_channel()});
                write_reg(ckbc_pkg::CFG_KEY_BLUE,  {5'($urandom), pick_key_channel()});
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_IDX_W'($urandom_range(ckbc_pkg::CFG_KEY_BLUE + 1,
                                                        (1 << CFG_IDX_W) - 1)),
                              13'($urandom));
                first = 1'b0;
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 9);
            mode = (roll == 0) ? FRAME_MIXED_PASS : (roll == 1) ? FRAME_REMASK : FRAME_CLEAN;
            w  = clamp_dim(frm_w_reg);
            h  = clamp_dim(frm_h_reg);
            x0 = $urandom_range(0, w - 1);
            x1 = $urandom_range(x0, w - 1);
            y0 = $urandom_range(0, h - 1);
            y1 = $urandom_range(y0, h - 1);
            stream_frame(mode, $urandom_range(0, 9) != 0, x0, x1, y0, y1,
                         $urandom_range(30, 100), 1'b1);
        end
        drain_stream();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    initial begin
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        aresetn         = 1'b0;
        tx_gaps_on      = 1'b1;
        rx_gaps_on      = 1'b1;
        rx_hold_request = 0;
        err_count       = 0;
        pixels_sent     = 0;
        model_reset();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_backpressure();
        test_restart_on_resize();
        test_wide_frame();
        test_tall_frame();
        test_random_frames();
        drain_stream();

        if (err_count == 0 && crop_out_q.size() == 0) begin
            $display("tb_color_key_bbox_crop: clean");
        end else begin
            $display("tb_color_key_bbox_crop: errors");
        end
        $finish;
    end

endmodule
